// ----- rtl/smrg_pkg.sv -----
package smrg_pkg;

  // Generator and shuffle table geometry.
  localparam int unsigned TableSize    = 32;
  localparam int unsigned WarmupSteps  = 8;
  localparam int unsigned LcgMult      = 16807;
  localparam int unsigned LcgMod       = 32'h7FFF_FFFF;
  localparam int unsigned NearOneLimit = 2147483390;

  localparam int unsigned GenW   = 32;
  localparam int unsigned ValW   = 31;
  localparam int unsigned MultW  = $clog2(LcgMult + 1);
  localparam int unsigned ProdW  = GenW + MultW;
  localparam int unsigned IdxW   = $clog2(TableSize);
  localparam int unsigned CntW   = $clog2(TableSize + WarmupSteps + 1);

  // The last output is split into TableSize buckets of this size. The bucket
  // size is a power of two for every power-of-two table size of two or more.
  localparam int unsigned BucketDiv = 1 + (LcgMod - 1) / TableSize;
  localparam int unsigned IdxShift  = $clog2(BucketDiv);

  typedef enum logic [2:0] {
    StFetch,
    StInitStart,
    StInitMul,
    StInitRed,
    StInitDone,
    StDrawFin,
    StSeedEmit
  } step_e;

  typedef enum logic [1:0] {
    JmpNext,
    JmpDispatch,
    JmpLoop,
    JmpWaitOut
  } jump_e;

  typedef struct packed {
    logic  in_ready;
    logic  ld_prod;
    logic  rd_mem;
    logic  ld_start;
    logic  loop_step;
    logic  ld_result;
    logic  ld_zero;
    jump_e jump;
    step_e target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic command;
    logic need_init;
    logic cnt_zero;
    logic out_free;
  } status_t;

  function automatic ctrl_t ucode(step_e step);
    ctrl_t c;
    c = '0;
    c.jump   = JmpNext;
    c.target = StFetch;
    case (step)
      StFetch: begin
        c.in_ready = 1'b1;
        c.ld_prod  = 1'b1;
        c.rd_mem   = 1'b1;
        c.jump     = JmpDispatch;
        c.target   = StFetch;
      end
      StInitStart: begin
        c.ld_start = 1'b1;
        c.target   = StInitMul;
      end
      StInitMul: begin
        c.ld_prod = 1'b1;
        c.target  = StInitRed;
      end
      StInitRed: begin
        c.loop_step = 1'b1;
        c.jump      = JmpLoop;
        c.target    = StInitDone;
      end
      StInitDone: begin
        c.ld_prod = 1'b1;
        c.rd_mem  = 1'b1;
        c.target  = StDrawFin;
      end
      StDrawFin: begin
        c.ld_result = 1'b1;
        c.jump      = JmpWaitOut;
        c.target    = StFetch;
      end
      StSeedEmit: begin
        c.ld_zero = 1'b1;
        c.jump    = JmpWaitOut;
        c.target  = StFetch;
      end
      default: begin
        c.target = StFetch;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/shuffled_minstd_random_generator_unit.sv -----
// Minimal-standard generator (x <- 16807 * x mod 2^31-1) behind a 32-entry
// shuffle table. A request with tuser set loads tdata as the new generator
// value and answers with a zero result; a request with tuser clear draws one
// 31-bit number, returned in m_axis_tdata with m_axis_tuser flagging values at
// or above 2147483390. A seed and an ordinary draw each take two steps, with
// the result registered in the second once the output register is free: the
// fetch step registers the product of the one multiplier, and the second step
// either reduces it and writes the drawn value or, for a seed, writes the zero
// result. A draw that must first rebuild the table (after reset, after a
// non-positive seed, or after a returned zero) adds a start step, a multiply
// and a reduce step for each of TableSize + WarmupSteps generator steps on the
// same multiplier and reduction, and a done step. One request is in work at a
// time; a new one is taken while the previous result still waits in the output
// register, but a result that finds that register still full holds the block
// in its last step until the register drains.
module shuffled_minstd_random_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value (signed)
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] random_value, [31] zero
  output logic        m_axis_tuser    // [0] near_one
);
  import smrg_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  logic [GenW-1:0]  g_q;
  logic [ProdW-1:0] prod_q;
  logic [ValW-1:0]  last_q;
  logic [CntW-1:0]  cnt_q;
  logic [ValW-1:0]  rd_q;
  logic [ValW-1:0]  mem [TableSize];

  logic            out_valid_q;
  logic [ValW-1:0] out_value_q;
  logic            out_near_q;

  logic            out_free;
  logic            draw_commit;
  logic            zero_commit;
  logic            accept;
  logic [GenW-1:0] sum;
  logic [ValW-1:0] red;
  logic [GenW-1:0] start_value;
  logic [ValW-1:0] bucket;
  logic [IdxW-1:0] idx;
  logic            cnt_in_table;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;

  smrg_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign out_free    = !out_valid_q || m_axis_tready;
  assign accept      = ctrl.in_ready && s_axis_tvalid;
  assign draw_commit = ctrl.ld_result && out_free;
  assign zero_commit = ctrl.ld_zero && out_free;

  always_comb begin
    status.in_valid  = s_axis_tvalid;
    status.command   = s_axis_tuser;
    status.need_init = g_q[GenW-1] || (g_q == '0) || (last_q == '0);
    status.cnt_zero  = (cnt_q == '0);
    status.out_free  = out_free;
  end

  // The product splits at bit 31; since 2^31 is one more than the modulus the
  // high part simply adds to the low part, and one subtraction finishes it.
  always_comb begin
    sum = GenW'(prod_q[ValW-1:0]) + GenW'(prod_q[ProdW-1:ValW]);
    if (sum >= GenW'(LcgMod)) begin
      red = ValW'(sum - GenW'(LcgMod));
    end else begin
      red = ValW'(sum);
    end
  end

  // A negative generator value restarts from its magnitude, anything else
  // from one; the most negative value becomes 2^31.
  assign start_value = g_q[GenW-1] ? (GenW'(0) - g_q) : GenW'(1);

  always_comb begin
    bucket = last_q >> IdxShift;
    if (bucket >= ValW'(TableSize)) begin
      idx = IdxW'(TableSize - 1);
    end else begin
      idx = bucket[IdxW-1:0];
    end
  end

  assign cnt_in_table = (cnt_q < CntW'(TableSize));
  assign mem_we       = (ctrl.loop_step && cnt_in_table) || draw_commit;
  assign mem_waddr    = ctrl.loop_step ? cnt_q[IdxW-1:0] : idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q    <= '0;
      last_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (accept && s_axis_tuser) begin
        g_q <= s_axis_tdata;
      end else if (ctrl.ld_start) begin
        g_q <= start_value;
      end else if (ctrl.loop_step || draw_commit) begin
        g_q <= GenW'(red);
      end

      if (ctrl.ld_start) begin
        cnt_q <= CntW'(TableSize + WarmupSteps - 1);
      end else if (ctrl.loop_step) begin
        cnt_q <= cnt_q - CntW'(1);
      end

      // The final rebuild step writes entry zero, which is also the new
      // last output.
      if (ctrl.loop_step && status.cnt_zero) begin
        last_q <= red;
      end else if (draw_commit) begin
        last_q <= rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_prod) begin
      prod_q <= ProdW'(g_q) * ProdW'(LcgMult);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= red;
    end
    if (ctrl.rd_mem) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (draw_commit || zero_commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_commit) begin
      out_value_q <= rd_q;
      out_near_q  <= (rd_q >= ValW'(NearOneLimit));
    end else if (zero_commit) begin
      out_value_q <= '0;
      out_near_q  <= 1'b0;
    end
  end

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_value_q};
  assign m_axis_tuser  = out_near_q;

endmodule

// ----- rtl/smrg_sequencer.sv -----
module smrg_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smrg_pkg::status_t status_i,
  output smrg_pkg::ctrl_t   ctrl_o
);
  import smrg_pkg::*;

  step_e step_q, step_d;
  ctrl_t ctrl;

  // Control word of the current step.
  always_comb begin
    ctrl = ucode(step_q);
  end

  always_comb begin
    step_d = step_q;
    case (ctrl.jump)
      JmpNext: begin
        step_d = ctrl.target;
      end
      JmpDispatch: begin
        if (status_i.in_valid) begin
          if (status_i.command) begin
            step_d = StSeedEmit;
          end else if (status_i.need_init) begin
            step_d = StInitStart;
          end else begin
            step_d = StDrawFin;
          end
        end
      end
      JmpLoop: begin
        step_d = status_i.cnt_zero ? ctrl.target : StInitMul;
      end
      JmpWaitOut: begin
        if (status_i.out_free) begin
          step_d = ctrl.target;
        end
      end
      default: begin
        step_d = StFetch;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StFetch;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

// ----- rtl/smrg_checker.sv -----
module smrg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import smrg_pkg::*;

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // A seed request has a result waiting after the step that emits its zero result.
  a_seed_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s_axis_tuser |-> ##2 m_axis_tvalid)
    else $error("no result after seed request");

  // The flag follows the value.
  a_near_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      !m_axis_tdata[31] &&
      (m_axis_tuser == (m_axis_tdata[30:0] >= ValW'(NearOneLimit))))
    else $error("near-one flag does not match value");

  logic unused_in;
  assign unused_in = ^s_axis_tdata;

endmodule

bind shuffled_minstd_random_generator_unit smrg_checker u_smrg_checker (.*);

// ----- test/shuffled_minstd_random_generator_unit_tb.sv -----
`timescale 1ns / 1ps

module shuffled_minstd_random_generator_unit_tb;

  import smrg_pkg::*;

  localparam logic CmdDraw = 1'b0;
  localparam logic CmdSeed = 1'b1;

  localparam int unsigned RandomRequests = 600;
  localparam int unsigned IdlePercent    = 30;
  localparam int unsigned DrainCycles    = 100;

  typedef struct {
    logic               command;
    logic signed [31:0] seed_value;
  } request_t;

  typedef struct {
    logic [ValW-1:0] random_value;
    logic            near_one;
  } draw_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;    // [31:0] seed_value (signed)
  logic        s_axis_tuser  = 1'b0;  // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [30:0] random_value, [31] zero
  logic        m_axis_tuser;          // [0] near_one

  shuffled_minstd_random_generator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted generator state.
  logic [GenW-1:0] gen_state;
  logic [ValW-1:0] last_state;
  logic [ValW-1:0] shuffle [TableSize];

  request_t    pending_requests [$];
  draw_t       expected_draws [$];
  request_t    in_flight;
  draw_t       oldest_draw;
  int unsigned accepted_requests = 0;
  int unsigned mismatch_count    = 0;
  logic        calm;

  // Neither side idles while this window of requests goes through.
  assign calm = (accepted_requests >= 250) && (accepted_requests < 400);

  function automatic logic [63:0] lcg_step(logic [63:0] x);
    return (x * 64'(LcgMult)) % 64'(LcgMod);
  endfunction

  function automatic void rebuild_table();
    logic [63:0] x;
    int          i;
    // A negative generator value is negated exactly, so -2^31 gives 2^31.
    if ($signed(gen_state) >= 0) begin
      x = 64'd1;
    end else begin
      x = -{{32{gen_state[31]}}, gen_state};
    end
    for (i = TableSize + WarmupSteps - 1; i >= 0; i--) begin
      x = lcg_step(x);
      if (i < TableSize) begin
        shuffle[i] = x[ValW-1:0];
      end
    end
    gen_state  = x[GenW-1:0];
    last_state = shuffle[0];
  endfunction

  function automatic draw_t predict_draw(request_t req);
    draw_t       res;
    logic [63:0] x;
    int unsigned idx;
    res.random_value = '0;
    res.near_one     = 1'b0;
    if (req.command == CmdSeed) begin
      gen_state = req.seed_value;
      return res;
    end
    if ($signed(gen_state) <= 0 || last_state == '0) begin
      rebuild_table();
    end
    x         = lcg_step({32'd0, gen_state});
    gen_state = x[GenW-1:0];
    idx       = last_state / BucketDiv;
    if (idx >= TableSize) begin
      idx = TableSize - 1;
    end
    res.random_value = shuffle[idx];
    res.near_one     = (res.random_value >= NearOneLimit);
    last_state       = res.random_value;
    shuffle[idx]     = gen_state[ValW-1:0];
    return res;
  endfunction

  task automatic push_request(logic command, logic [31:0] seed_value);
    request_t req;
    req.command    = command;
    req.seed_value = seed_value;
    pending_requests.push_back(req);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= CmdDraw;
      gen_state     = '0;
      last_state    = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_draws.push_back(predict_draw(in_flight));
        accepted_requests <= accepted_requests + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 &&
            (calm || $urandom_range(0, 99) >= IdlePercent)) begin
          in_flight = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= in_flight.seed_value;
          s_axis_tuser  <= in_flight.command;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_draws.size() == 0) begin
          $error("result with nothing expected: random_value %0d near_one %0b",
                 m_axis_tdata[ValW-1:0], m_axis_tuser);
          mismatch_count++;
        end else begin
          oldest_draw = expected_draws.pop_front();
          if (m_axis_tdata[ValW-1:0] !== oldest_draw.random_value) begin
            $error("random_value: expected %0d, actual %0d",
                   oldest_draw.random_value, m_axis_tdata[ValW-1:0]);
            mismatch_count++;
          end
          if (m_axis_tdata[31] !== 1'b0) begin
            $error("tdata padding: expected 0, actual %0b", m_axis_tdata[31]);
            mismatch_count++;
          end
          if (m_axis_tuser !== oldest_draw.near_one) begin
            $error("near_one: expected %0b, actual %0b",
                   oldest_draw.near_one, m_axis_tuser);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  initial begin
    int unsigned n;
    logic [31:0] v;
    // Draws straight after reset, at the seed extremes, with non-positive
    // seeds and with a seed equal to the modulus, which puts a zero into the
    // table that later draws may return.
    push_request(CmdDraw, 32'h0);
    push_request(CmdDraw, 32'hFFFF_FFFF);
    push_request(CmdDraw, 32'h0);
    push_request(CmdSeed, 32'd1);
    push_request(CmdDraw, 32'h0);
    push_request(CmdSeed, 32'd2147483646);
    push_request(CmdDraw, 32'h0);
    push_request(CmdDraw, 32'h0);
    push_request(CmdSeed, 32'd0);
    push_request(CmdDraw, 32'h0);
    push_request(CmdSeed, 32'hFFFF_FFFF);
    push_request(CmdDraw, 32'h0);
    push_request(CmdSeed, 32'h8000_0001);
    push_request(CmdDraw, 32'h0);
    push_request(CmdSeed, 32'h8000_0000);
    push_request(CmdDraw, 32'h0);
    push_request(CmdSeed, LcgMod);
    push_request(CmdDraw, 32'h0);
    push_request(CmdSeed, 32'h1234_5678);
    push_request(CmdDraw, 32'h0);
    push_request(CmdDraw, 32'h0);
    push_request(CmdDraw, 32'h0);

    for (n = 0; n < RandomRequests; n++) begin
      if ($urandom_range(0, 99) < 7) begin
        case ($urandom_range(0, 5))
          0: v = $urandom_range(1, 2147483646);
          1: begin
            v = $urandom_range(1, 32'h7FFF_FFFF);
            v = -v;
          end
          2: v = 32'd0;
          3: v = LcgMod;
          4: v = $urandom;
          default: v = $urandom_range(1, 1000);
        endcase
        push_request(CmdSeed, v);
      end else begin
        // The data word of a draw is ignored by the block.
        push_request(CmdDraw, $urandom);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || s_axis_tvalid || expected_draws.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("shuffled_minstd_random_generator_unit_tb: PASS");
    end else begin
      $display("shuffled_minstd_random_generator_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("shuffled_minstd_random_generator_unit_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/smrg_pkg.sv
rtl/smrg_sequencer.sv
rtl/shuffled_minstd_random_generator_unit.sv
rtl/smrg_checker.sv
test/shuffled_minstd_random_generator_unit_tb.sv
